>>> rtl/hfc_pkg.sv
`timescale 1ns / 1ps
// hfc_pkg: shared types, constants and the crc-8 function for the
// humidity / temperature frame check and convert block; no dependencies

package hfc_pkg;

    localparam int RAW_W   = 16;
    localparam int CRC_W   = 8;
    localparam int SCALE_W = 15;
    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;

    localparam logic [SCALE_W-1:0] TEMP_SCALE = 15'd17500;
    localparam logic [SCALE_W-1:0] HUM_SCALE  = 15'd10000;
    localparam logic [TEMP_W:0]    TEMP_OFFSET = 16'd4500;
    localparam logic [RAW_W:0]     DIV_CONST  = 17'd65535;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h31;
    localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_ERR  = 2'd1,
        ST_TEMP_CRC = 2'd2,
        ST_HUM_CRC  = 2'd3
    } t_status;

    // msb-first crc-8 over both bytes of a word, high byte first
    function automatic logic [CRC_W-1:0] crc8_word(input logic [RAW_W-1:0] w);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = CRC_INIT;
        for (int i = RAW_W - 1; i >= 0; i--) begin
            fb  = crc[CRC_W-1] ^ w[i];
            crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

>>> rtl/hfc_lane.sv
`timescale 1ns / 1ps
// hfc_lane: one word lane, crc check and scaled conversion floor(scale*raw/65535)
// depends on hfc_pkg

module hfc_lane #(
    parameter logic [hfc_pkg::SCALE_W-1:0] SCALE = hfc_pkg::TEMP_SCALE,
    parameter int                          Q_W   = hfc_pkg::TEMP_W
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [hfc_pkg::RAW_W-1:0]   i_raw,
    input  logic [hfc_pkg::CRC_W-1:0]   i_crc,
    output logic                        o_crc_ok,
    output logic [Q_W-1:0]              o_value
);
    import hfc_pkg::*;

    localparam int PROD_W = RAW_W + SCALE_W;
    localparam int Q0_W   = PROD_W - RAW_W;

    logic [PROD_W-1:0] prod;
    logic [Q0_W-1:0]   q0;
    logic [RAW_W:0]    rem0;
    logic [Q0_W-1:0]   quot;
    logic              r_crc_ok;
    logic [Q_W-1:0]    r_value;

    // divide by 65535: estimate with a shift, one remainder correction
    always_comb begin
        prod = PROD_W'(i_raw) * PROD_W'(SCALE);
        q0   = prod[PROD_W-1:RAW_W];
        rem0 = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q0);
        quot = (rem0 >= DIV_CONST) ? q0 + Q0_W'(1) : q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_crc_ok <= (crc8_word(i_raw) == i_crc);
            r_value  <= quot[Q_W-1:0];
        end
    end

    assign o_crc_ok = r_crc_ok;
    assign o_value  = r_value;

endmodule

>>> rtl/hfc_merge.sv
`timescale 1ns / 1ps
// hfc_merge: combines lane results into status, updates held values,
// owns pipeline valid bits and the output register; depends on hfc_pkg

module hfc_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_bus_error,
    input  logic                               i_temp_ok,
    input  logic [hfc_pkg::TEMP_W-1:0]         i_temp_q,
    input  logic                               i_hum_ok,
    input  logic [hfc_pkg::HUM_W-1:0]          i_hum_q,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [hfc_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [hfc_pkg::HUM_W-1:0]          o_humidity_centi
);
    import hfc_pkg::*;

    logic                     r_s1_valid;
    logic                     r_s1_bus_error;
    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [TEMP_W-1:0] r_held_temp;
    logic [HUM_W-1:0]         r_held_hum;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [HUM_W-1:0]         r_out_hum;

    logic                     out_free;
    logic                     advance;
    t_status                  n_status;
    logic signed [TEMP_W-1:0] n_held_temp;
    logic [HUM_W-1:0]         n_held_hum;
    logic signed [TEMP_W:0]   temp_wide;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;

    always_comb begin
        temp_wide   = signed'({1'b0, i_temp_q}) - signed'(TEMP_OFFSET);
        n_status    = ST_OK;
        n_held_temp = r_held_temp;
        n_held_hum  = r_held_hum;
        if (r_s1_bus_error) begin
            n_status = ST_BUS_ERR;
        end else if (!i_temp_ok) begin
            n_status = ST_TEMP_CRC;
        end else begin
            n_held_temp = temp_wide[TEMP_W-1:0];
            if (!i_hum_ok) begin
                n_status = ST_HUM_CRC;
            end else begin
                n_held_hum = i_hum_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_temp <= '0;
            r_held_hum  <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_held_temp <= n_held_temp;
                r_held_hum  <= n_held_hum;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_bus_error <= i_bus_error;
        end
        if (advance) begin
            r_status   <= n_status;
            r_out_temp <= n_held_temp;
            r_out_hum  <= n_held_hum;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_temperature_centi = r_out_temp;
    assign o_humidity_centi    = r_out_hum;

endmodule

>>> rtl/humidity_temp_frame_check_convert.sv
`timescale 1ns / 1ps
// humidity_temp_frame_check_convert: top level, two word lanes and the merge stage
// depends on hfc_pkg, hfc_lane, hfc_merge
//
// input channel: i_valid / o_ready, one beat carries a six-byte sensor frame
//   (bus error flag, temperature word and crc, humidity word and crc)
// output channel: o_valid / i_ready, one beat per frame with status and
//   both held values (temperature in 0.01 degC, humidity in 0.01 %rh)
// the temperature and humidity lanes check crc-8 and scale their word in
//   parallel, then the merge stage picks the status and updates held values
// path: each frame is registered in the lane stage, then in the output register
// throughput: one frame per cycle while the output is taken, set by the single
//   lane stage and merge stage; a waiting output still lets the lane stage fill
// stall: when i_ready is low the output beat holds, the lane stage fills
//   and then o_ready drops until the output is taken
// reset: synchronous, active low, empties the pipeline and clears both
//   held values to zero

module humidity_temp_frame_check_convert #(
    parameter logic [hfc_pkg::SCALE_W-1:0] TEMP_SCALE = hfc_pkg::TEMP_SCALE,
    parameter logic [hfc_pkg::SCALE_W-1:0] HUM_SCALE  = hfc_pkg::HUM_SCALE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_bus_error,
    input  logic [hfc_pkg::RAW_W-1:0]          i_temp_raw,
    input  logic [hfc_pkg::CRC_W-1:0]          i_temp_crc,
    input  logic [hfc_pkg::RAW_W-1:0]          i_hum_raw,
    input  logic [hfc_pkg::CRC_W-1:0]          i_hum_crc,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic signed [hfc_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [hfc_pkg::HUM_W-1:0]          o_humidity_centi
);
    import hfc_pkg::*;

    logic              load;
    logic              temp_ok;
    logic [TEMP_W-1:0] temp_q;
    logic              hum_ok;
    logic [HUM_W-1:0]  hum_q;

    assign load = i_valid && o_ready;

    hfc_lane #(
        .SCALE (TEMP_SCALE),
        .Q_W   (TEMP_W)
    ) u_temp_lane (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_raw    (i_temp_raw),
        .i_crc    (i_temp_crc),
        .o_crc_ok (temp_ok),
        .o_value  (temp_q)
    );

    hfc_lane #(
        .SCALE (HUM_SCALE),
        .Q_W   (HUM_W)
    ) u_hum_lane (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_raw    (i_hum_raw),
        .i_crc    (i_hum_crc),
        .o_crc_ok (hum_ok),
        .o_value  (hum_q)
    );

    hfc_merge u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_bus_error         (i_bus_error),
        .i_temp_ok           (temp_ok),
        .i_temp_q            (temp_q),
        .i_hum_ok            (hum_ok),
        .i_hum_q             (hum_q),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi)
    );

endmodule
